### rtl/mcl_pkg.sv
package mcl_pkg;

   localparam int DEF_LINES  = 1024;
   localparam int ADDR_W     = 32;
   localparam int MOD_STEPS  = 3;
   localparam int STEP_W     = $clog2(MOD_STEPS);
   localparam int CSR_AW     = 2;
   localparam int CSR_DW     = 32;

   localparam logic [CSR_AW-1:0] CSR_OWN_ID = CSR_AW'(0);

   localparam logic MODE_PROC  = 1'b0;
   localparam logic MODE_SNOOP = 1'b1;

   typedef enum logic [2:0] {
      ST_I  = 3'd0,
      ST_IS = 3'd1,
      ST_IM = 3'd2,
      ST_S  = 3'd3,
      ST_SM = 3'd4,
      ST_M  = 3'd5
   } line_state_type;

   typedef enum logic [2:0] {
      MSG_LOAD  = 3'd0,
      MSG_STORE = 3'd1,
      MSG_GETS  = 3'd2,
      MSG_GETM  = 3'd3,
      MSG_DATA  = 3'd4
   } msg_type;

   typedef enum logic [2:0] {
      ACT_NONE = 3'd0,
      ACT_GETS = 3'd1,
      ACT_GETM = 3'd2,
      ACT_PROC = 3'd3,
      ACT_BUS  = 3'd4
   } action_type;

   typedef struct packed {
      logic load;
      logic mod_step;
      logic clr_wr;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic slot_free;
   } stat_type;

endpackage

### rtl/mcl_if.sv
interface mcl_req_if;
   import mcl_pkg::*;
   logic              valid;
   logic              ready;
   logic              mode;
   logic [2:0]        msg;
   logic [ADDR_W-1:0] addr;
   logic [3:0]        src_id;

   modport source (output valid, mode, msg, addr, src_id, input ready);
   modport sink   (input valid, mode, msg, addr, src_id, output ready);
endinterface

interface mcl_rsp_if;
   import mcl_pkg::*;
   logic              valid;
   logic              ready;
   logic [2:0]        action;
   logic [ADDR_W-1:0] out_addr;
   logic [3:0]        dest_id;
   logic              miss;
   logic              error;
   logic [31:0]       miss_total;
   logic [2:0]        line_state_out;

   modport source (output valid, action, out_addr, dest_id, miss, error, miss_total,
                   line_state_out, input ready);
   modport sink   (input valid, action, out_addr, dest_id, miss, error, miss_total,
                   line_state_out, output ready);
endinterface

### rtl/mcl_csr.sv
module mcl_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [mcl_pkg::CSR_AW-1:0] paddr,
   input  logic [mcl_pkg::CSR_DW-1:0] pwdata,
   output logic [mcl_pkg::CSR_DW-1:0] prdata,
   output logic                       pready,
   output logic [3:0]                 own_id
);
   import mcl_pkg::*;

   logic [3:0] own_id_ff;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && (paddr == CSR_OWN_ID);

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff <= 4'd0;
      end else if (wr_en) begin
         own_id_ff <= pwdata[3:0];
      end
   end

   always_comb begin
      prdata = '0;
      unique case (paddr)
         CSR_OWN_ID: prdata = {(CSR_DW-4)'(0), own_id_ff};
         default:    prdata = '0;
      endcase
   end

   assign own_id = own_id_ff;

endmodule

### rtl/mcl_ctrl.sv
module mcl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  mcl_pkg::stat_type  stat,
   output mcl_pkg::cmd_type   cmd
);
   import mcl_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MOD,
      S_READ,
      S_CALC
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_W'(MOD_STEPS - 1)) state_in = S_READ;
         end
         S_READ: begin
            state_in = S_CALC;
         end
         S_CALC: begin
            if (stat.slot_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

### rtl/mcl_dp.sv
module mcl_dp #(
   parameter int LINES = mcl_pkg::DEF_LINES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mcl_pkg::cmd_type           cmd,
   output mcl_pkg::stat_type          stat,
   input  logic [3:0]                 own_id,
   input  logic                       req_mode,
   input  logic [2:0]                 req_msg,
   input  logic [mcl_pkg::ADDR_W-1:0] req_addr,
   input  logic [3:0]                 req_src_id,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic [2:0]                 rsp_action,
   output logic [mcl_pkg::ADDR_W-1:0] rsp_out_addr,
   output logic [3:0]                 rsp_dest_id,
   output logic                       rsp_miss,
   output logic                       rsp_error,
   output logic [31:0]                rsp_miss_total,
   output logic [2:0]                 rsp_line_state_out
);
   import mcl_pkg::*;

   localparam int IW = (LINES > 1) ? $clog2(LINES) : 1;
   localparam logic [IW:0] LINES_W = (IW+1)'(LINES);
   localparam bit                POW2      = (LINES & (LINES - 1)) == 0;
   localparam longint unsigned   RECIP     = (64'd1 << ADDR_W) / LINES;
   localparam logic [ADDR_W-1:0] RECIP_W   = ADDR_W'(RECIP);
   localparam logic [ADDR_W-1:0] LINES_A   = ADDR_W'(LINES);
   localparam logic [ADDR_W-1:0] LINE_MASK = ADDR_W'(LINES - 1);

   // beat fields held for the life of the item
   logic              mode_ff;
   logic [2:0]        msg_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [3:0]        src_ff;

   // remainder unit: reciprocal quotient estimate, multiply back, one correction
   logic [2*ADDR_W-1:0] prod;
   logic [ADDR_W-1:0]   q_ff, q_in;
   logic [ADDR_W-1:0]   qd, diff;
   logic [IW:0]         r_ff, r_in, r_sub;
   logic [IW-1:0]       rem_ff, rem_in;

   logic [2:0]    mem [LINES];
   logic [2:0]    rd_ff;
   logic [IW-1:0] clr_ff;
   logic          we;
   logic [IW-1:0] wa;
   logic [2:0]    wd;

   line_state_type st, ns;
   action_type     act;
   logic           miss, err;

   logic [31:0]    miss_ff;
   logic [31:0]    miss_sum;
   logic           valid_ff;

   always_comb begin
      prod   = {{ADDR_W{1'b0}}, addr_ff} * {{ADDR_W{1'b0}}, RECIP_W};
      q_in   = prod[2*ADDR_W-1:ADDR_W];
      qd     = q_ff * LINES_A;
      diff   = POW2 ? (addr_ff & LINE_MASK) : (addr_ff - qd);
      r_in   = diff[IW:0];
      r_sub  = r_ff - LINES_W;
      rem_in = (r_ff >= LINES_W) ? r_sub[IW-1:0] : r_ff[IW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         msg_ff  <= req_msg;
         addr_ff <= req_addr;
         src_ff  <= req_src_id;
      end else if (cmd.mod_step) begin
         q_ff   <= q_in;
         r_ff   <= r_in;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   assign stat.clr_last  = (clr_ff == IW'(LINES - 1));
   assign stat.slot_free = !valid_ff || rsp_ready;

   assign we = cmd.clr_wr || cmd.commit;
   assign wa = cmd.clr_wr ? clr_ff : rem_ff;
   assign wd = cmd.clr_wr ? ST_I : ns;

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[rem_ff];
   end

   always_comb begin
      st   = (rd_ff > ST_M) ? ST_I : line_state_type'(rd_ff);
      ns   = st;
      act  = ACT_NONE;
      miss = 1'b0;
      err  = 1'b0;
      if (mode_ff == MODE_PROC) begin
         case (msg_ff) inside
            MSG_LOAD, MSG_STORE: begin
               unique case (st)
                  ST_I: begin
                     act  = (msg_ff == MSG_LOAD) ? ACT_GETS : ACT_GETM;
                     ns   = (msg_ff == MSG_LOAD) ? ST_IS : ST_IM;
                     miss = 1'b1;
                  end
                  ST_S: begin
                     if (msg_ff == MSG_LOAD) begin
                        act = ACT_PROC;
                     end else begin
                        act  = ACT_GETM;
                        ns   = ST_SM;
                        miss = 1'b1;
                     end
                  end
                  ST_M:    act = ACT_PROC;
                  default: err = 1'b1;
               endcase
            end
            default: err = 1'b1;
         endcase
      end else begin
         case (msg_ff) inside
            MSG_GETS, MSG_GETM, MSG_DATA: begin
               unique case (st)
                  ST_IS: begin
                     if (msg_ff == MSG_DATA) begin
                        act = ACT_PROC;
                        ns  = ST_S;
                     end
                  end
                  ST_IM: begin
                     if (msg_ff == MSG_DATA) begin
                        act = ACT_PROC;
                        ns  = ST_M;
                     end
                  end
                  ST_S: begin
                     if (msg_ff == MSG_GETM) ns = ST_I;
                  end
                  ST_SM: begin
                     if (msg_ff == MSG_GETM) begin
                        if (src_ff != own_id) ns = ST_IM;
                     end else if (msg_ff == MSG_DATA) begin
                        act = ACT_PROC;
                        ns  = ST_M;
                     end
                  end
                  ST_M: begin
                     if (msg_ff == MSG_GETS) begin
                        act = ACT_BUS;
                        ns  = ST_S;
                     end else if (msg_ff == MSG_GETM) begin
                        act = ACT_BUS;
                        ns  = ST_I;
                     end else begin
                        err = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            default: err = 1'b1;
         endcase
      end
   end

   assign miss_sum = miss_ff + {31'd0, miss};

   always_ff @(posedge clock) begin
      if (reset) begin
         miss_ff  <= '0;
         valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         miss_ff  <= miss_sum;
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_action         <= act;
         rsp_out_addr       <= (act != ACT_NONE) ? addr_ff : '0;
         rsp_dest_id        <= (act == ACT_BUS) ? src_ff : 4'd0;
         rsp_miss           <= miss;
         rsp_error          <= err;
         rsp_miss_total     <= miss_sum;
         rsp_line_state_out <= ns;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

### rtl/msi_coherence_line_controller_core.sv
// Snooping MSI line controller: one beat in (processor LOAD/STORE or snooped GETS/GETM/DATA)
// gives one beat out with the action, the line's new state, a miss flag and the running
// 32-bit miss count. The line is addr modulo LINES. Items are handled one at a time, so a new
// beat is taken only after the last one's result is committed. The remainder by LINES is
// worked out in steps (a reciprocal multiply for a quotient estimate, a multiply-back and
// subtract, then one correcting subtract; a plain mask when LINES is a power of two), followed
// by the registered read of the line-state memory and then the state update and write-back.
// A stalled result holds the update back until it is taken. A finished result waits in the
// output register while the next beat is taken. After reset the line-state memory is swept to
// I, one line a cycle, so no beat is taken until the sweep is done; own_id may be written over
// the APB port at any time the block is idle.
module msi_coherence_line_controller_core #(
   parameter int LINES = mcl_pkg::DEF_LINES
) (
   input  logic                       clock,
   input  logic                       reset,
   mcl_req_if.sink                    req_ch,
   mcl_rsp_if.source                  rsp_ch,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [mcl_pkg::CSR_AW-1:0] paddr,
   input  logic [mcl_pkg::CSR_DW-1:0] pwdata,
   output logic [mcl_pkg::CSR_DW-1:0] prdata,
   output logic                       pready
);
   import mcl_pkg::*;

   cmd_type    cmd;
   stat_type   stat;
   logic [3:0] own_id;

   mcl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .own_id  (own_id)
   );

   mcl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mcl_dp #(
      .LINES (LINES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .own_id             (own_id),
      .req_mode           (req_ch.mode),
      .req_msg            (req_ch.msg),
      .req_addr           (req_ch.addr),
      .req_src_id         (req_ch.src_id),
      .rsp_ready          (rsp_ch.ready),
      .rsp_valid          (rsp_ch.valid),
      .rsp_action         (rsp_ch.action),
      .rsp_out_addr       (rsp_ch.out_addr),
      .rsp_dest_id        (rsp_ch.dest_id),
      .rsp_miss           (rsp_ch.miss),
      .rsp_error          (rsp_ch.error),
      .rsp_miss_total     (rsp_ch.miss_total),
      .rsp_line_state_out (rsp_ch.line_state_out)
   );

endmodule

### rtl/mcl_checker.sv
module mcl_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_action,
   input logic [31:0] rsp_out_addr,
   input logic [3:0]  rsp_dest_id,
   input logic        rsp_miss,
   input logic        rsp_error,
   input logic [31:0] rsp_miss_total,
   input logic [2:0]  rsp_line_state_out
);
   import mcl_pkg::*;

   logic        beat;
   logic [31:0] total_ff;

   assign beat = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (beat) begin
         total_ff <= rsp_miss_total;
      end
   end

   a_total_steps: assert property (@(posedge clock) disable iff (reset)
      beat |-> rsp_miss_total == total_ff + {31'd0, rsp_miss})
      else $error("miss total does not follow previous beat");

   a_error_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_action == ACT_NONE && !rsp_miss)
      else $error("error beat carries an action or a miss");

   a_miss_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_miss |-> rsp_action == ACT_GETS || rsp_action == ACT_GETM)
      else $error("miss without a bus request");

   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_NONE |-> rsp_out_addr == '0 && rsp_dest_id == '0)
      else $error("address or destination set without an action");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_line_state_out)
                                  && $stable(rsp_miss_total))
      else $error("result beat dropped or changed while stalled");

endmodule

bind msi_coherence_line_controller_core mcl_checker u_mcl_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_action         (rsp_ch.action),
   .rsp_out_addr       (rsp_ch.out_addr),
   .rsp_dest_id        (rsp_ch.dest_id),
   .rsp_miss           (rsp_ch.miss),
   .rsp_error          (rsp_ch.error),
   .rsp_miss_total     (rsp_ch.miss_total),
   .rsp_line_state_out (rsp_ch.line_state_out)
);
